### sv/bct_pkg.sv
// Shared widths for the binomial coefficient table.
`timescale 1ns / 1ps
`default_nettype none
package bct_pkg;
  localparam int N_W    = 8;   // n and r input fields
  localparam int ROW_W  = 7;   // row index and row counter
  localparam int COEF_W = 63;  // coefficient width
  localparam int IN_W   = 16;  // s_tdata width
  localparam int OUT_W  = 64;  // m_tdata width
endpackage
`default_nettype wire

### sv/binomial_coefficient_table.sv
// Binomial coefficient C(n, r) from a Pascal triangle built on demand in a memory.
// A word whose rows are already built is read from memory on acceptance and its result is
// registered onto m_tdata in S_RESULT (one memory read per word); no further word is taken
// until the block is back in S_IDLE. A word that needs new rows first builds rows rows_filled .. n
// (S_FILL_RD, S_FILL_TAIL, S_FILL_EDGE) with separate memory read and write ports, then an S_LOOKUP read.
// Reset (rst, synchronous) empties the row count at once; the table needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module binomial_coefficient_table
  import bct_pkg::*;
#(
  parameter int MAX_N = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // [7:0] n_total, [15:8] choose_count
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // [62:0] coefficient, [63] zero
  output logic                   m_tuser    // [0] out_of_range
);

  localparam int DIM   = MAX_N + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [N_W-1:0] MAX_N_S = N_W'(MAX_N);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL_RD,
    S_FILL_TAIL,
    S_FILL_EDGE,
    S_LOOKUP,
    S_RESULT
  } state_t;

  state_t              state;
  logic [ROW_W-1:0]    rows_filled;
  logic [AW-1:0]       wr_base;
  logic [ROW_W-1:0]    k;
  logic [ROW_W-1:0]    pk;
  logic                pv;
  logic [COEF_W-1:0]   prev;
  logic [ROW_W-1:0]    n_q;
  logic [ROW_W-1:0]    r_q;
  logic [COEF_W-1:0]   res_coef;
  logic                res_oor;
  logic                res_mem;

  logic [COEF_W-1:0]   mem [DEPTH];
  logic [COEF_W-1:0]   rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [COEF_W-1:0]   wr_data;

  logic signed [N_W-1:0] n_in;
  logic signed [N_W-1:0] r_in;
  logic [ROW_W-1:0]      n_in7;
  logic [ROW_W-1:0]      r_in7;
  logic                  accept;
  logic                  fill_rd;
  logic                  out_free;
  logic [AW-1:0]         in_addr;
  logic [AW-1:0]         q_addr;

  assign n_in     = signed'(s_tdata[N_W-1:0]);
  assign r_in     = signed'(s_tdata[2*N_W-1:N_W]);
  assign n_in7    = n_in[ROW_W-1:0];
  assign r_in7    = r_in[ROW_W-1:0];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fill_rd  = (state == S_FILL_RD) && (k != rows_filled);
  assign out_free = !m_tvalid || m_tready;
  assign in_addr  = AW'(AW'(n_in7) * AW'(DIM)) + AW'(r_in7);
  assign q_addr   = AW'(AW'(n_q) * AW'(DIM)) + AW'(r_q);

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = wr_base - AW'(DIM) + AW'(k);
    wr_en   = 1'b0;
    wr_addr = wr_base + AW'(pk);
    wr_data = (pk == '0) ? COEF_W'(1) : COEF_W'(prev + rd_data);
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = in_addr;
    end else if (state == S_LOOKUP) begin
      rd_en   = 1'b1;
      rd_addr = q_addr;
    end else if (fill_rd) begin
      rd_en = 1'b1;
    end
    if (pv) begin
      wr_en = 1'b1;
    end else if (state == S_FILL_EDGE) begin
      wr_en   = 1'b1;
      wr_addr = wr_base + AW'(rows_filled);
      wr_data = COEF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_filled <= '0;
      wr_base     <= '0;
      pv          <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      pv <= fill_rd;
      pk <= k;
      if (pv) begin
        prev <= rd_data;
      end
      if (m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_q <= n_in7;
            r_q <= r_in7;
            if (n_in > MAX_N_S) begin
              res_coef <= '0;
              res_oor  <= 1'b1;
              res_mem  <= 1'b0;
              state    <= S_RESULT;
            end else if (r_in < 0 || r_in > n_in) begin
              res_coef <= '0;
              res_oor  <= 1'b0;
              res_mem  <= 1'b0;
              state    <= S_RESULT;
            end else if (r_in == 0 || r_in == n_in) begin
              res_coef <= COEF_W'(1);
              res_oor  <= 1'b0;
              res_mem  <= 1'b0;
              state    <= S_RESULT;
            end else if (rows_filled > n_in7) begin
              res_coef <= '0;
              res_oor  <= 1'b0;
              res_mem  <= 1'b1;
              state    <= S_RESULT;
            end else begin
              res_coef <= '0;
              res_oor  <= 1'b0;
              res_mem  <= 1'b1;
              k        <= '0;
              state    <= S_FILL_RD;
            end
          end
        end
        S_FILL_RD: begin
          if (k == rows_filled) begin
            state <= S_FILL_TAIL;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FILL_TAIL: begin
          state <= S_FILL_EDGE;
        end
        S_FILL_EDGE: begin
          rows_filled <= rows_filled + 1'b1;
          wr_base     <= wr_base + AW'(DIM);
          k           <= '0;
          if (rows_filled >= n_q) begin
            state <= S_LOOKUP;
          end else begin
            state <= S_FILL_RD;
          end
        end
        S_LOOKUP: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, (res_mem ? rd_data : res_coef)};
            m_tuser  <= res_oor;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/bct_checker.sv
// Port-level checks for the binomial coefficient table, bound into every binomial_coefficient_table instance.
`timescale 1ns / 1ps
`default_nettype none
module bct_checker
  import bct_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [IN_W-1:0]  s_tdata,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             m_tuser
);

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("out_of_range word carries a non-zero coefficient");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[OUT_W-1])
    else $error("padding bit of m_tdata set");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again before the previous word finished");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

endmodule

bind binomial_coefficient_table bct_checker u_bct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

### dv/binomial_coefficient_table_tb.sv
// Self-checking testbench for the binomial coefficient table: directed and random C(n, r) words.
`timescale 1ns / 1ps
`default_nettype none
module binomial_coefficient_table_tb;
  import bct_pkg::*;

  localparam int MAX_N       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic              oor;
  } binom_result_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;   // [7:0] n_total, [15:8] choose_count
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // [62:0] coefficient, [63] zero
  logic              m_tuser;   // [0] out_of_range

  binom_result_t     coef_expected_q[$];
  logic [COEF_W-1:0] pascal_rows[0:MAX_N][0:MAX_N];
  int                rows_built;
  int                mismatches;
  int                cycle_count;
  int                src_idle_pct;
  int                sink_idle_pct;
  int                sink_hold_cycles;

  binomial_coefficient_table #(.MAX_N(MAX_N)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // rows are built in order up to the highest n so far that needed a table lookup
  function automatic binom_result_t binom_predict(input logic signed [7:0] n,
                                                  input logic signed [7:0] r);
    binom_result_t res;
    int            i;
    int            j;
    res = '0;
    if (n > MAX_N) begin
      res.oor = 1'b1;
    end else if (r < 0 || r > n) begin
      res.coef = '0;
    end else if (r == 0 || r == n) begin
      res.coef = COEF_W'(1);
    end else begin
      while (rows_built <= int'(n)) begin
        i = rows_built;
        pascal_rows[i][0] = COEF_W'(1);
        pascal_rows[i][i] = COEF_W'(1);
        for (j = 1; j < i; j++) begin
          pascal_rows[i][j] = pascal_rows[i-1][j-1] + pascal_rows[i-1][j];
        end
        rows_built++;
      end
      res.coef = pascal_rows[int'(n)][int'(r)];
    end
    return res;
  endfunction

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    binom_result_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (coef_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: coef=%0d oor=%0b", m_tdata[COEF_W-1:0], m_tuser);
        end else begin
          exp_res = coef_expected_q.pop_front();
          if (m_tdata[COEF_W-1:0] !== exp_res.coef || m_tuser !== exp_res.oor ||
              m_tdata[OUT_W-1:COEF_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: coef exp %0d got %0d, oor exp %0b got %0b, pad got %0b",
                       exp_res.coef, m_tdata[COEF_W-1:0], exp_res.oor, m_tuser,
                       m_tdata[OUT_W-1:COEF_W]);
          end
        end
      end
      if (s_tvalid && s_tready)
        coef_expected_q = {coef_expected_q, binom_predict(s_tdata[7:0], s_tdata[15:8])};
    end
  end

  // receiver: random stalls, plus a counted hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        m_tready = 1'b0;
        sink_hold_cycles--;
      end else begin
        m_tready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_word(input int n, input int r);
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 4);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {N_W'(r), N_W'(n)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (coef_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_trivial_cases();
    send_word(0, 0);
    send_word(1, 1);
    send_word(7, 0);
    send_word(7, 7);
    send_word(64, 0);
    send_word(64, 64);
    send_word(5, 6);
    send_word(5, -1);
    send_word(0, -128);
    send_word(64, 127);
    send_word(-1, 0);
    send_word(-128, -128);
    send_word(-5, -5);
    wait_drain();
  endtask

  task automatic test_out_of_range();
    send_word(65, 0);
    send_word(65, 65);
    send_word(100, 50);
    send_word(127, 127);
    send_word(127, -128);
    wait_drain();
  endtask

  // small rows first so the table grows in steps
  task automatic test_interior_values();
    send_word(2, 1);
    send_word(5, 2);
    send_word(10, 5);
    send_word(64, 1);
    send_word(64, 32);
    send_word(63, 31);
    send_word(64, 63);
    wait_drain();
  endtask

  task automatic test_backpressure();
    int k;
    int n;
    src_idle_pct     = 0;
    sink_hold_cycles = 300;
    for (k = 0; k < 40; k++) begin
      n = $urandom_range(0, MAX_N);
      send_word(n, $urandom_range(0, n));
    end
    wait_drain();
    src_idle_pct = IDLE_PCT;
  endtask

  task automatic test_random();
    int k;
    int n;
    int r;
    for (k = 0; k < 985; k++) begin
      src_idle_pct  = (k >= 400 && k < 550) ? 0 : IDLE_PCT;
      sink_idle_pct = src_idle_pct;
      if ($urandom_range(99) < 85) begin
        n = $urandom_range(0, MAX_N);
        r = $urandom_range(0, n);
      end else begin
        n = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end
      send_word(n, r);
    end
    wait_drain();
  endtask

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    rows_built       = 0;
    mismatches       = 0;
    cycle_count      = 0;
    src_idle_pct     = IDLE_PCT;
    sink_idle_pct    = IDLE_PCT;
    sink_hold_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_trivial_cases();
    test_out_of_range();
    test_interior_values();
    test_backpressure();
    test_random();

    sink_idle_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && coef_expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
